// ===== sv/bcs_pkg.sv =====
// Shared types, constants and decode helpers for the byte CPU step block.
// Used by bcs_ctrl, bcs_dpath and byte_cpu_step; no dependencies.
package bcs_pkg;

   // Memory geometry
   localparam int MEM_DEPTH = 256;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int DATA_W    = 8;

   typedef logic [DATA_W-1:0] byte_type;
   typedef logic [MEM_AW-1:0] addr_type;

   // Request kinds on req_opcode
   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_STEP  = 2'd1,
      REQ_START = 2'd2
   } req_op_type;

   // Instruction operations (low nibble)
   localparam logic [3:0] OPN_COPY = 4'd1;
   localparam logic [3:0] OPN_ADD  = 4'd2;
   localparam logic [3:0] OPN_JZ   = 4'd3;
   localparam logic [3:0] OPN_EMIT = 4'd4;
   localparam logic [3:0] OPN_HALT = 4'd5;

   // Instruction flag bit positions
   localparam int INS_RD1_BIT = 4;
   localparam int INS_RD0_BIT = 5;
   localparam int INS_WR_BIT  = 6;
   localparam int INS_TWO_BIT = 7;

   // Memory read address source
   typedef enum logic [1:0] {
      RD_PC   = 2'd0,
      RD_ARG0 = 2'd1,
      RD_ARG1 = 2'd2
   } rd_sel_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS,
      ST_WADDR,
      ST_ARG0,
      ST_ARG1,
      ST_RD0_REQ,
      ST_RD0_CAP,
      ST_RD1_REQ,
      ST_RD1_CAP,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      logic       wr_load;   // 1: write request data, 0: write result
      logic       pc_load;
      logic       pc_inc;
      logic       clr_halt;
      logic       set_halt;
      logic       clr_char;
      logic       ld_ins;
      logic       ld_waddr;
      logic       ld_arg0;
      logic       ld_arg1;
      logic       exec;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      byte_type rdata;  // registered memory read word
      byte_type ins;    // latched instruction
   } status_type;

   function automatic logic [3:0] ins_op(input byte_type ins);
      return ins[3:0];
   endfunction

endpackage

// ===== sv/bcs_dpath.sv =====
// Datapath of the byte CPU step block: unified memory, program counter,
// argument, result and status registers. Depends on bcs_pkg.
module bcs_dpath (
   input  logic                clock,
   input  logic                reset,
   input  bcs_pkg::cmd_type    cmd,
   input  bcs_pkg::byte_type   req_address,
   input  bcs_pkg::byte_type   req_data,
   output bcs_pkg::status_type status,
   output logic                rsp_halted,
   output logic                rsp_char_valid,
   output bcs_pkg::byte_type   rsp_char_out,
   output bcs_pkg::byte_type   rsp_program_counter
);
   import bcs_pkg::*;

   byte_type mem [MEM_DEPTH];
   byte_type rdata_ff;

   byte_type pc_ff, pc_in;
   byte_type arg0_ff, arg0_in;
   byte_type arg1_ff, arg1_in;
   byte_type result_ff, result_in;
   byte_type ins_ff, ins_in;
   byte_type waddr_ff, waddr_in;
   logic     halt_ff, halt_in;
   logic     cvalid_ff, cvalid_in;
   byte_type char_ff, char_in;

   addr_type rd_addr;
   addr_type wr_addr;
   byte_type wr_data;
   logic     jump_taken;

   // Read address select
   always_comb begin
      unique case (cmd.rd_sel)
         RD_ARG0: rd_addr = arg0_ff[MEM_AW-1:0];
         RD_ARG1: rd_addr = arg1_ff[MEM_AW-1:0];
         default: rd_addr = pc_ff[MEM_AW-1:0];
      endcase
   end

   // Operation result
   always_comb begin
      result_in = result_ff;
      if (cmd.exec) begin
         if (ins_op(ins_ff) == OPN_COPY) begin
            result_in = arg0_ff;
         end else if (ins_op(ins_ff) == OPN_ADD) begin
            result_in = arg0_ff + arg1_ff;
         end
      end
   end

   assign jump_taken = cmd.exec && (ins_op(ins_ff) == OPN_JZ) && (arg1_ff == '0);

   // Write port source: load request or write-back of the result
   assign wr_addr = cmd.wr_load ? req_address[MEM_AW-1:0] : waddr_ff[MEM_AW-1:0];
   assign wr_data = cmd.wr_load ? req_data : result_in;

   // Single-port memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Next values of the architectural registers
   always_comb begin
      pc_in = pc_ff;
      priority if (cmd.pc_load) begin
         pc_in = req_address;
      end else if (cmd.pc_inc) begin
         pc_in = pc_ff + 8'd1;
      end else if (jump_taken) begin
         pc_in = arg0_ff;
      end

      arg0_in  = cmd.ld_arg0  ? rdata_ff : arg0_ff;
      arg1_in  = cmd.ld_arg1  ? rdata_ff : arg1_ff;
      ins_in   = cmd.ld_ins   ? rdata_ff : ins_ff;
      waddr_in = cmd.ld_waddr ? rdata_ff : waddr_ff;

      halt_in = halt_ff;
      if (cmd.clr_halt) begin
         halt_in = 1'b0;
      end else if (cmd.set_halt) begin
         halt_in = 1'b1;
      end

      cvalid_in = cvalid_ff;
      char_in   = char_ff;
      if (cmd.clr_char) begin
         cvalid_in = 1'b0;
         char_in   = '0;
      end else if (cmd.exec && ins_op(ins_ff) == OPN_EMIT) begin
         cvalid_in = 1'b1;
         char_in   = arg1_ff;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         arg0_ff   <= '0;
         arg1_ff   <= '0;
         result_ff <= '0;
         halt_ff   <= 1'b0;
         cvalid_ff <= 1'b0;
         char_ff   <= '0;
      end else begin
         pc_ff     <= pc_in;
         arg0_ff   <= arg0_in;
         arg1_ff   <= arg1_in;
         result_ff <= result_in;
         halt_ff   <= halt_in;
         cvalid_ff <= cvalid_in;
         char_ff   <= char_in;
      end
   end

   // Per-instruction scratch, no reset needed
   always_ff @(posedge clock) begin
      ins_ff   <= ins_in;
      waddr_ff <= waddr_in;
   end

   assign status.rdata = rdata_ff;
   assign status.ins   = ins_ff;

   assign rsp_halted          = halt_ff;
   assign rsp_char_valid      = cvalid_ff;
   assign rsp_char_out        = char_ff;
   assign rsp_program_counter = pc_ff;

   // Single port: never read and write in one cycle
   assert property (@(posedge clock) disable iff (reset) !(cmd.mem_rd && cmd.mem_wr))
      else $error("memory read and write in the same cycle");
   // A write-back only follows a loaded write address
   assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr && !cmd.wr_load) |-> cmd.exec && ins_ff[INS_WR_BIT])
      else $error("result write without write flag");
   // Emit leaves char_out at zero unless char is valid
   assert property (@(posedge clock) disable iff (reset) !cvalid_ff |-> char_ff == '0)
      else $error("char_out nonzero while char_valid low");

endmodule

// ===== sv/bcs_ctrl.sv =====
// Controller of the byte CPU step block: sequences fetches, indirect
// reads, execute and response. Depends on bcs_pkg.
module bcs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_opcode,
   input  bcs_pkg::status_type status,
   output bcs_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import bcs_pkg::*;

   state_type state_ff, state_in;

   // Where to go once the argument fetches are done
   function automatic state_type after_args(input byte_type ins);
      if (ins[INS_RD0_BIT]) begin
         return ST_RD0_REQ;
      end else if (ins[INS_RD1_BIT]) begin
         return ST_RD1_REQ;
      end
      return ST_EXEC;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_PC;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.clr_char = 1'b1;
               state_in     = ST_RESP;
               unique case (req_opcode)
                  REQ_LOAD: begin
                     cmd.mem_wr  = 1'b1;
                     cmd.wr_load = 1'b1;
                  end
                  REQ_START: begin
                     cmd.pc_load  = 1'b1;
                     cmd.clr_halt = 1'b1;
                  end
                  REQ_STEP: begin
                     cmd.mem_rd = 1'b1;
                     cmd.pc_inc = 1'b1;
                     state_in   = ST_INS;
                  end
                  default: ;
               endcase
            end
         end
         ST_INS: begin
            cmd.ld_ins = 1'b1;
            if (ins_op(status.rdata) == OPN_HALT) begin
               cmd.set_halt = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.pc_inc = 1'b1;
               state_in   = status.rdata[INS_WR_BIT] ? ST_WADDR : ST_ARG0;
            end
         end
         ST_WADDR: begin
            cmd.ld_waddr = 1'b1;
            cmd.mem_rd   = 1'b1;
            cmd.pc_inc   = 1'b1;
            state_in     = ST_ARG0;
         end
         ST_ARG0: begin
            cmd.ld_arg0 = 1'b1;
            if (status.ins[INS_TWO_BIT]) begin
               cmd.mem_rd = 1'b1;
               cmd.pc_inc = 1'b1;
               state_in   = ST_ARG1;
            end else begin
               state_in = after_args(status.ins);
            end
         end
         ST_ARG1: begin
            cmd.ld_arg1 = 1'b1;
            state_in    = after_args(status.ins);
         end
         ST_RD0_REQ: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_ARG0;
            state_in   = ST_RD0_CAP;
         end
         ST_RD0_CAP: begin
            cmd.ld_arg0 = 1'b1;
            state_in    = status.ins[INS_RD1_BIT] ? ST_RD1_REQ : ST_EXEC;
         end
         ST_RD1_REQ: begin
            // copy dereferences argument 0 a second time
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = (ins_op(status.ins) == OPN_COPY) ? RD_ARG0 : RD_ARG1;
            state_in   = ST_RD1_CAP;
         end
         ST_RD1_CAP: begin
            if (ins_op(status.ins) == OPN_COPY) begin
               cmd.ld_arg0 = 1'b1;
            end else begin
               cmd.ld_arg1 = 1'b1;
            end
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec   = 1'b1;
            cmd.mem_wr = status.ins[INS_WR_BIT];
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   // An accepted word makes the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");
   // Response is followed by idle
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("block stayed busy after response");
   // Execute is always followed directly by the response
   assert property (@(posedge clock) disable iff (reset) cmd.exec |=> rsp_valid)
      else $error("execute not followed by response");

endmodule

// ===== sv/byte_cpu_step.sv =====
// Top level of the byte CPU step block: controller plus datapath.
// Depends on bcs_pkg, bcs_ctrl and bcs_dpath.
//
// A word is taken when start is high and busy is low; busy then stays high
// until the single response word has been shown on rsp_* with rsp_valid for
// one cycle, and the next word can be taken in the cycle after that. The
// receiver cannot stall. Load, start and unused request words go from the
// accepting cycle straight to the response; a step reads the opcode and,
// unless it is a halt, the write address if flagged, the arguments and the
// indirect reads, then executes: the single-port 256-byte memory does one
// access a cycle with a registered read, and each of these fetches and
// reads costs one memory access. The memory has no reset: program bytes
// must be loaded before they are run.
module byte_cpu_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  bcs_pkg::byte_type  req_address,
   input  bcs_pkg::byte_type  req_data,
   output logic               rsp_valid,
   output logic               rsp_halted,
   output logic               rsp_char_valid,
   output bcs_pkg::byte_type  rsp_char_out,
   output bcs_pkg::byte_type  rsp_program_counter
);
   import bcs_pkg::*;

   cmd_type    cmd;
   status_type status;

   bcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   bcs_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_address         (req_address),
      .req_data            (req_data),
      .status              (status),
      .rsp_halted          (rsp_halted),
      .rsp_char_valid      (rsp_char_valid),
      .rsp_char_out        (rsp_char_out),
      .rsp_program_counter (rsp_program_counter)
   );

endmodule
